/* hdl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge, skipped while rst_n is low.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property checked on every rising clk edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hdl/mcs_pkg.sv */
// ---------------------------------------------------------------------------
// mcs_pkg
// Types, opcode tables and constants of the MAC command splitter.
// ---------------------------------------------------------------------------
`default_nettype none

package mcs_pkg;

  localparam int BYTE_W   = 8;
  localparam int BUF_W    = 40;
  localparam int BUF_BYTES = BUF_W / BYTE_W;
  localparam int CNT_W    = 3;
  localparam int MAX_PARAMS = 5;
  // Number of parameter bytes actually kept per command.
  localparam int STORED_LIMIT = (MAX_PARAMS < BUF_BYTES) ? MAX_PARAMS : BUF_BYTES;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 56;

  // Known opcodes among 0x00..0x0F, one mask per table.
  localparam logic [15:0] KNOWN_DN = 16'hFFFE;
  localparam logic [15:0] KNOWN_UP = 16'hBFFE;

  localparam logic [CNT_W-1:0] PARAM_LEN_DN [16] = '{
    3'd0, 3'd1, 3'd2, 3'd4, 3'd1, 3'd4, 3'd0, 3'd5,
    3'd1, 3'd1, 3'd4, 3'd1, 3'd1, 3'd5, 3'd2, 3'd1
  };
  localparam logic [CNT_W-1:0] PARAM_LEN_UP [16] = '{
    3'd0, 3'd1, 3'd0, 3'd1, 3'd0, 3'd1, 3'd2, 3'd1,
    3'd0, 3'd0, 3'd1, 3'd1, 3'd0, 3'd0, 3'd0, 3'd1
  };

  typedef enum logic [1:0] {
    ST_COMPLETE = 2'd0,
    ST_TRUNC    = 2'd1,
    ST_UNKNOWN  = 2'd2
  } status_t;

  typedef struct packed {
    logic             known;
    logic [CNT_W-1:0] plen;
  } lkp_t;

  typedef struct packed {
    logic              emit;
    logic [BYTE_W-1:0] opcode;
    logic [BUF_W-1:0]  params;
    logic [CNT_W-1:0]  count;
    status_t           status;
    logic              eof;
  } result_t;

endpackage

`default_nettype wire

/* hdl/mac_command_splitter_unit.sv */
// ---------------------------------------------------------------------------
// mac_command_splitter_unit
// Splits a stream of MAC command bytes into commands with their parameters.
// ---------------------------------------------------------------------------
//
// Channel  Direction  Beat contents
// in_      slave      tdata[7:0] byte_value, tdata[15:8] frame_length,
//                     tuser first_byte
// out_     master     tdata[7:0] opcode, [47:8] param_bytes, [50:48] param_count,
//                     tuser[1:0] status, tlast end_of_frame
// cfg_     slave      cfg_data = table_select (0 downlink, 1 uplink table)
//
// Each input beat is registered, then parsed into the output register; while
// the output is not stalled, one beat can enter every cycle. The parser step
// between the two registers is combinational. Reset is synchronous on rst_n
// low and clears valid flags, parser state and table_select. A stalled output
// holds both stages; the input stage accepts while it is empty or while the
// output register is free or being drained.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mac_command_splitter_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [mcs_pkg::IN_DATA_W-1:0] in_tdata,   // byte_value, frame_length
  input  wire logic                          in_tuser,   // first_byte
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [mcs_pkg::OUT_DATA_W-1:0]     out_tdata,  // opcode, param_bytes, param_count
  output logic [1:0]                         out_tuser,  // status
  output logic                               out_tlast,  // end_of_frame
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic                          cfg_data    // table_select
);
  import mcs_pkg::*;

  // Input stage.
  logic                 in_v_r;
  logic [BYTE_W-1:0]    in_byte_r;
  logic [BYTE_W-1:0]    in_len_r;
  logic                 in_first_r;

  // Output register.
  logic                 out_v_r;
  result_t              out_r;

  logic                 table_sel_r;
  logic                 adv;
  result_t              res;

  // The parser consumes the registered beat whenever the output register can
  // take whatever it produces.
  assign adv       = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_sel_r <= 1'b0;
    end else if (cfg_valid) begin
      table_sel_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_v_r <= 1'b1;
    end else if (adv) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r  <= in_tdata[BYTE_W-1:0];
      in_len_r   <= in_tdata[2*BYTE_W-1:BYTE_W];
      in_first_r <= in_tuser;
    end
  end

  mcs_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (adv),
    .byte_value   (in_byte_r),
    .first_byte   (in_first_r),
    .frame_length (in_len_r),
    .table_sel    (table_sel_r),
    .res          (res)
  );

  // A beat that yields no command still advances the parser but leaves the
  // output register alone.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv && res.emit) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res.emit) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(OUT_DATA_W-BYTE_W-BUF_W-CNT_W){1'b0}},
                       out_r.count, out_r.params, out_r.opcode};
  assign out_tuser  = out_r.status;
  assign out_tlast  = out_r.eof;

  // Only complete commands carry parameters.
  `ASSERT_CLK(a_no_params_unless_complete,
    out_v_r && (out_r.status != ST_COMPLETE) |-> (out_r.count == '0) && (out_r.params == '0),
    "parameters reported on a truncated or unknown command")
  `ASSERT_CLK(a_count_limit,
    out_v_r |-> (out_r.count <= CNT_W'(STORED_LIMIT)),
    "parameter count beyond stored limit")
  // A held input beat must not be lost or altered while the parser waits.
  `ASSERT_CLK(a_in_stage_holds,
    in_v_r && !adv |=> in_v_r && $stable(in_byte_r) && $stable(in_first_r) && $stable(in_len_r),
    "input stage changed while stalled")
  `ASSERT_ALWAYS(a_reset_clears,
    !rst_n |=> !out_v_r && !in_v_r,
    "valid flags not cleared by reset")

endmodule

`default_nettype wire

/* hdl/mcs_lookup.sv */
// ---------------------------------------------------------------------------
// mcs_lookup
// Opcode table lookup: known flag and parameter byte count.
// ---------------------------------------------------------------------------
`default_nettype none

module mcs_lookup (
  input  wire logic [mcs_pkg::BYTE_W-1:0] opcode,
  input  wire logic                       table_sel,
  output mcs_pkg::lkp_t                   lkp
);
  import mcs_pkg::*;

  logic [3:0] low_nib;
  logic       in_range;

  assign low_nib  = opcode[3:0];
  assign in_range = (opcode[BYTE_W-1:4] == 4'd0);

  always_comb begin
    if (table_sel) begin
      lkp.known = in_range && KNOWN_UP[low_nib];
      lkp.plen  = PARAM_LEN_UP[low_nib];
    end else begin
      lkp.known = in_range && KNOWN_DN[low_nib];
      lkp.plen  = PARAM_LEN_DN[low_nib];
    end
  end

endmodule

`default_nettype wire

/* hdl/mcs_parser.sv */
// ---------------------------------------------------------------------------
// mcs_parser
// Frame parsing state and the per-byte command decision.
// ---------------------------------------------------------------------------
`default_nettype none

module mcs_parser (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       step,
  input  wire logic [mcs_pkg::BYTE_W-1:0] byte_value,
  input  wire logic                       first_byte,
  input  wire logic [mcs_pkg::BYTE_W-1:0] frame_length,
  input  wire logic                       table_sel,
  output mcs_pkg::result_t                res
);
  import mcs_pkg::*;

  localparam logic [CNT_W-1:0] LIM = CNT_W'(STORED_LIMIT);

  logic [BYTE_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0]  pend_r, pend_nxt;
  logic [CNT_W-1:0]  total_r, total_nxt;
  logic [BYTE_W-1:0] held_r, held_nxt;
  logic [BUF_W-1:0]  buf_r, buf_nxt;

  logic [BYTE_W-1:0] rem0, left;
  logic [CNT_W-1:0]  pend0, total0, idx, pend1;
  logic [BYTE_W-1:0] held0;
  logic [BUF_W-1:0]  buf0, buf_fill;
  lkp_t              lkp;

  mcs_lookup u_lookup (
    .opcode    (byte_value),
    .table_sel (table_sel),
    .lkp       (lkp)
  );

  // A first byte restarts the frame before the byte itself is parsed.
  always_comb begin
    if (first_byte) begin
      rem0   = (frame_length == '0) ? BYTE_W'(1) : frame_length;
      pend0  = '0;
      total0 = '0;
      held0  = '0;
      buf0   = '0;
    end else begin
      rem0   = rem_r;
      pend0  = pend_r;
      total0 = total_r;
      held0  = held_r;
      buf0   = buf_r;
    end
  end

  assign left  = rem0 - BYTE_W'(1);
  assign idx   = total0 - pend0;
  assign pend1 = pend0 - CNT_W'(1);

  always_comb begin
    buf_fill = buf0;
    for (int i = 0; i < STORED_LIMIT; i++) begin
      if (idx == CNT_W'(i)) begin
        buf_fill[i*BYTE_W +: BYTE_W] = byte_value;
      end
    end
  end

  always_comb begin
    rem_nxt   = rem0;
    pend_nxt  = pend0;
    total_nxt = total0;
    held_nxt  = held0;
    buf_nxt   = buf0;
    res        = '0;
    res.status = ST_COMPLETE;
    res.eof    = (left == '0);
    if (rem0 != '0) begin
      rem_nxt = left;
      if (pend0 != '0) begin
        pend_nxt = pend1;
        buf_nxt  = buf_fill;
        if (pend1 == '0) begin
          res.emit   = 1'b1;
          res.opcode = held0;
          res.params = buf_fill;
          res.count  = (total0 < LIM) ? total0 : LIM;
          buf_nxt    = '0;
          total_nxt  = '0;
        end
      end else if (!lkp.known) begin
        res.emit   = 1'b1;
        res.opcode = byte_value;
        res.status = ST_UNKNOWN;
      end else if (lkp.plen == '0) begin
        res.emit   = 1'b1;
        res.opcode = byte_value;
      end else if ({{(BYTE_W-CNT_W){1'b0}}, lkp.plen} > left) begin
        res.emit   = 1'b1;
        res.opcode = byte_value;
        res.status = ST_TRUNC;
      end else begin
        held_nxt  = byte_value;
        pend_nxt  = lkp.plen;
        total_nxt = lkp.plen;
        buf_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r   <= '0;
      pend_r  <= '0;
      total_r <= '0;
      held_r  <= '0;
      buf_r   <= '0;
    end else if (step) begin
      rem_r   <= rem_nxt;
      pend_r  <= pend_nxt;
      total_r <= total_nxt;
      held_r  <= held_nxt;
      buf_r   <= buf_nxt;
    end
  end

endmodule

`default_nettype wire
